// File: rtl/assert_macros.svh
// Assertion macros shared by the timer slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define STT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define STT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/stt_pkg.sv
// Package with codes, widths and record types of the timer slot table.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    localparam int SLOTS_DEF     = 20;
    localparam int ACTION_W      = 2;
    localparam int TICKS_W       = 8;
    localparam int SLOT_FIELD_W  = 5;
    localparam int KIND_W        = 3;
    localparam int COUNT_FIELD_W = 5;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_TICK       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START      = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CANCEL     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CANCEL_ALL = 2'd3;

    // Response kinds
    localparam logic [KIND_W-1:0] KIND_STARTED       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL          = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED         = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE_TICK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CANCELLED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REJECTED      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ALL_CANCELLED = 3'd6;

    // One timer entry as kept in the slot memory
    typedef struct packed {
        logic [TICKS_W-1:0] period;
        logic [TICKS_W-1:0] remaining;
        logic [TICKS_W-1:0] repeats;
    } slot_rec_t;

    // Result of one countdown step on a slot
    typedef struct packed {
        logic      fire;
        logic      final_fire;
        slot_rec_t rec_next;
    } slot_upd_t;

endpackage

`default_nettype wire

// File: rtl/stt_cmd_if.sv
// Request channel interface of the timer slot table.
`timescale 1ns / 1ps
`default_nettype none

interface stt_cmd_if import stt_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [ACTION_W-1:0]     action;
    logic [TICKS_W-1:0]      period_ticks;
    logic [TICKS_W-1:0]      repeat_count;
    logic [SLOT_FIELD_W-1:0] slot_index;

    modport source (output valid, action, period_ticks, repeat_count, slot_index,
                    input ready);
    modport sink   (input valid, action, period_ticks, repeat_count, slot_index,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/stt_rsp_if.sv
// Response channel interface of the timer slot table.
`timescale 1ns / 1ps
`default_nettype none

interface stt_rsp_if import stt_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        result_kind;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic                     final_fire;
    logic [COUNT_FIELD_W-1:0] slots_in_use;
    logic                     last_of_run;

    modport source (output valid, result_kind, slot, final_fire, slots_in_use, last_of_run,
                    input ready);
    modport sink   (input valid, result_kind, slot, final_fire, slots_in_use, last_of_run,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/software_timer_slot_table.sv
// Top level of the software timer slot table: sequencer, slot flags and response register.
//
// Usage: requests enter on cmd (tick, start, cancel one slot, cancel all) and
// responses leave on rsp, both valid/ready; a transaction completes on a
// rising edge with valid and ready high. cmd.ready is high only while the
// sequencer is idle, so one request is worked at a time.
// Tick: the shared countdown unit walks the slots one per cycle through the
// slot memory, except while a fire waits on a stalled rsp; one fired response
// per expiring slot in slot order, or a single idle-tick response. The last
// response of each request carries last_of_run.
// Start: the free-slot search walks the slot flags one per cycle. Cancel and
// cancel-all are answered from the single-response state.
// A finished response waits in the output register; a new request is taken
// meanwhile, and the sequencer holds whenever it has a response to hand over
// while rsp is stalled.
// Reset clears every slot flag and the active count at once; the slot memory
// needs no clearing since a start writes an entry before any tick reads it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module software_timer_slot_table import stt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    stt_cmd_if.sink    cmd,
    stt_rsp_if.source  rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TICK = 3'd1;
    localparam logic [2:0] S_TEND = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_ONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   eval_reg, eval_next;
    logic [SLOTS-1:0]   active_reg, active_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_slot_reg, pend_slot_next;
    logic               pend_final_reg, pend_final_next;
    logic [CNT_W-1:0]   pend_cnt_reg, pend_cnt_next;

    logic [KIND_W-1:0]  one_kind_reg, one_kind_next;
    logic [IDX_W-1:0]   one_slot_reg, one_slot_next;
    logic [TICKS_W-1:0] st_period_reg, st_period_next;
    logic [TICKS_W-1:0] st_repeats_reg, st_repeats_next;

    logic                     out_valid_reg;
    logic [KIND_W-1:0]        out_kind_reg;
    logic [SLOT_FIELD_W-1:0]  out_slot_reg;
    logic                     out_final_reg;
    logic [COUNT_FIELD_W-1:0] out_cnt_reg;
    logic                     out_last_reg;

    logic               push;
    logic [KIND_W-1:0]  push_kind;
    logic [IDX_W-1:0]   push_slot;
    logic               push_final;
    logic [CNT_W-1:0]   push_cnt;
    logic               push_last;
    logic               out_free;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_rec_t          wr_data;
    logic [IDX_W-1:0]   rd_addr;
    slot_rec_t          rd_data;
    slot_upd_t          upd;

    logic [IDX_W+SLOT_FIELD_W-1:0]  idx_wide;
    logic [IDX_W-1:0]               cidx;
    logic                           idx_ok;
    logic [IDX_W+SLOT_FIELD_W-1:0]  push_slot_wide;
    logic [CNT_W+COUNT_FIELD_W-1:0] push_cnt_wide;

    // Map the cancel index onto the slot index width
    assign idx_wide = {{IDX_W{1'b0}}, cmd.slot_index};
    assign cidx     = idx_wide[IDX_W-1:0];
    assign idx_ok   = ({{(32 - SLOT_FIELD_W){1'b0}}, cmd.slot_index} < 32'(SLOTS));

    assign cmd.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    stt_slot_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stt_slot_unit u_unit (
        .active (active_reg[eval_reg]),
        .rec    (rd_data),
        .upd    (upd)
    );

    // Sequence requests, slot walks and response hand-over
    always_comb
    begin
        state_next      = state_reg;
        eval_next       = eval_reg;
        active_next     = active_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_final_next = pend_final_reg;
        pend_cnt_next   = pend_cnt_reg;
        one_kind_next   = one_kind_reg;
        one_slot_next   = one_slot_reg;
        st_period_next  = st_period_reg;
        st_repeats_next = st_repeats_reg;
        push            = 1'b0;
        push_kind       = KIND_IDLE_TICK;
        push_slot       = '0;
        push_final      = 1'b0;
        push_cnt        = cnt_reg;
        push_last       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = eval_reg;
        wr_data         = upd.rec_next;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    eval_next = '0;
                    case (cmd.action)
                        ACT_TICK:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = S_TICK;
                        end
                        ACT_START:
                        begin
                            st_period_next  = cmd.period_ticks;
                            st_repeats_next = cmd.repeat_count;
                            if (cmd.period_ticks == '0)
                            begin
                                one_kind_next = KIND_REJECTED;
                                one_slot_next = '0;
                                state_next    = S_ONE;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            if (idx_ok && active_reg[cidx])
                            begin
                                active_next[cidx] = 1'b0;
                                cnt_next          = cnt_reg - 1'b1;
                                one_kind_next     = KIND_CANCELLED;
                                one_slot_next     = cidx;
                            end
                            else
                            begin
                                one_kind_next = KIND_REJECTED;
                                one_slot_next = '0;
                            end
                            state_next = S_ONE;
                        end
                        default:
                        begin
                            active_next   = '0;
                            cnt_next      = '0;
                            one_kind_next = KIND_ALL_CANCELLED;
                            one_slot_next = '0;
                            state_next    = S_ONE;
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                rd_addr = eval_reg;
                // Hold while a fire must push out a pending response to a stalled port
                if (!(upd.fire && pend_valid_reg) || out_free)
                begin
                    if (eval_reg != LAST_IDX)
                    begin
                        rd_addr = eval_reg + 1'b1;
                    end
                    wr_en = active_reg[eval_reg];
                    if (upd.fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            push       = 1'b1;
                            push_kind  = KIND_FIRED;
                            push_slot  = pend_slot_reg;
                            push_final = pend_final_reg;
                            push_cnt   = pend_cnt_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = eval_reg;
                        pend_final_next = upd.final_fire;
                        pend_cnt_next   = cnt_reg;
                        if (upd.final_fire)
                        begin
                            active_next[eval_reg] = 1'b0;
                            cnt_next              = cnt_reg - 1'b1;
                            pend_cnt_next         = cnt_reg - 1'b1;
                        end
                    end
                    if (eval_reg == LAST_IDX)
                    begin
                        state_next = S_TEND;
                    end
                    else
                    begin
                        eval_next = eval_reg + 1'b1;
                    end
                end
            end

            S_TEND:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        push_kind  = KIND_FIRED;
                        push_slot  = pend_slot_reg;
                        push_final = pend_final_reg;
                        push_cnt   = pend_cnt_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_FIND:
            begin
                if (!active_reg[eval_reg])
                begin
                    if (out_free)
                    begin
                        wr_en                 = 1'b1;
                        wr_data.period        = st_period_reg;
                        wr_data.remaining     = st_period_reg;
                        wr_data.repeats       = st_repeats_reg;
                        active_next[eval_reg] = 1'b1;
                        cnt_next              = cnt_reg + 1'b1;
                        push                  = 1'b1;
                        push_kind             = KIND_STARTED;
                        push_slot             = eval_reg;
                        push_cnt              = cnt_reg + 1'b1;
                        push_last             = 1'b1;
                        state_next            = S_IDLE;
                    end
                end
                else if (eval_reg == LAST_IDX)
                begin
                    one_kind_next = KIND_FULL;
                    one_slot_next = '0;
                    state_next    = S_ONE;
                end
                else
                begin
                    eval_next = eval_reg + 1'b1;
                end
            end

            S_ONE:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_kind  = one_kind_reg;
                    push_slot  = one_slot_reg;
                    push_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Fit slot and count into the response field widths
    assign push_slot_wide = {{SLOT_FIELD_W{1'b0}}, push_slot};
    assign push_cnt_wide  = {{COUNT_FIELD_W{1'b0}}, push_cnt};

    // Payload registers
    always_ff @(posedge clk)
    begin
        eval_reg       <= eval_next;
        pend_slot_reg  <= pend_slot_next;
        pend_final_reg <= pend_final_next;
        pend_cnt_reg   <= pend_cnt_next;
        one_kind_reg   <= one_kind_next;
        one_slot_reg   <= one_slot_next;
        st_period_reg  <= st_period_next;
        st_repeats_reg <= st_repeats_next;
        if (push)
        begin
            out_kind_reg  <= push_kind;
            out_slot_reg  <= push_slot_wide[SLOT_FIELD_W-1:0];
            out_final_reg <= push_final;
            out_cnt_reg   <= push_cnt_wide[COUNT_FIELD_W-1:0];
            out_last_reg  <= push_last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_kind  = out_kind_reg;
    assign rsp.slot         = out_slot_reg;
    assign rsp.final_fire   = out_final_reg;
    assign rsp.slots_in_use = out_cnt_reg;
    assign rsp.last_of_run  = out_last_reg;

    // Checks
    `STT_ASSERT(a_count_matches_flags, clk, rst_n,
                cnt_reg == CNT_W'($countones(active_reg)),
                "active count differs from slot flags")
    `STT_ASSERT_IMP(a_pend_only_in_tick, clk, rst_n, pend_valid_reg,
                    (state_reg == S_TICK) || (state_reg == S_TEND),
                    "pending fire outside a tick walk")
    `STT_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, cmd.valid && cmd.ready,
                    state_reg != S_IDLE,
                    "accepted request not started")
    `STT_ASSERT_IMP(a_final_only_fired, clk, rst_n, out_valid_reg && out_final_reg,
                    out_kind_reg == KIND_FIRED,
                    "final flag on a non-fire response")

endmodule

`default_nettype wire

// File: rtl/stt_slot_unit.sv
// Shared countdown unit: decrements one slot and decides reload, repeat or free.
`timescale 1ns / 1ps
`default_nettype none

module stt_slot_unit import stt_pkg::*;
(
    input  wire logic      active,
    input  var  slot_rec_t rec,
    output slot_upd_t      upd
);

    logic [TICKS_W-1:0] rem_dec;
    logic               fire;

    // Count down and detect expiry
    assign rem_dec = rec.remaining - 1'b1;
    assign fire    = active && (rem_dec == '0);

    // Reload on expiry, step the repeat count unless it means forever
    always_comb
    begin
        upd.fire               = fire;
        upd.final_fire         = fire && (rec.repeats == TICKS_W'(1));
        upd.rec_next.period    = rec.period;
        upd.rec_next.remaining = fire ? rec.period : rem_dec;
        upd.rec_next.repeats   = rec.repeats;
        if (fire && (rec.repeats != '0))
        begin
            upd.rec_next.repeats = rec.repeats - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/stt_slot_mem.sv
// Slot record memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module stt_slot_mem import stt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IDX_W = 5
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  var  slot_rec_t        wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output slot_rec_t             rd_data
);

    slot_rec_t mem [SLOTS];
    slot_rec_t rd_data_reg;

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the software timer slot table: predictor, stimulus and checks.
`timescale 1ns / 1ps

module testbench;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 450;

    // One response as the block should present it
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic                     final_fire;
        logic [COUNT_FIELD_W-1:0] in_use;
        logic                     last;
    } timer_result_t;

    // Timer table predictor and queue of awaited responses
    class timer_scoreboard;
        logic [TICKS_W-1:0] period_tab    [SLOTS_DEF];
        logic [TICKS_W-1:0] remaining_tab [SLOTS_DEF];
        logic [TICKS_W-1:0] repeats_tab   [SLOTS_DEF];
        int unsigned        live_count;
        timer_result_t      awaited [$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        fire_count;
        int unsigned        full_count;
        int unsigned        idle_ticks;

        function new();
            foreach (period_tab[i])
            begin
                period_tab[i]    = '0;
                remaining_tab[i] = '0;
                repeats_tab[i]   = '0;
            end
            live_count = 0;
            errors     = 0;
            checked    = 0;
            fire_count = 0;
            full_count = 0;
            idle_ticks = 0;
        endfunction

        function timer_result_t make_result(logic [KIND_W-1:0] kind, int slot, logic fin);
            timer_result_t res;
            res.kind       = kind;
            res.slot       = SLOT_FIELD_W'(slot);
            res.final_fire = fin;
            res.in_use     = COUNT_FIELD_W'(live_count);
            res.last       = 1'b0;
            return res;
        endfunction

        // Work out the responses of one accepted request and queue them
        function void note_request(logic [ACTION_W-1:0] act, logic [TICKS_W-1:0] per,
                                   logic [TICKS_W-1:0] rep, logic [SLOT_FIELD_W-1:0] idx);
            timer_result_t batch [$];
            int            free_slot;
            free_slot = -1;
            case (act)
                ACT_TICK:
                begin
                    for (int i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (period_tab[i] == 0)
                            continue;
                        remaining_tab[i] = remaining_tab[i] - 1'b1;
                        if (remaining_tab[i] != 0)
                            continue;
                        if (repeats_tab[i] == 1)
                        begin
                            period_tab[i] = '0;
                            live_count--;
                            batch.push_back(make_result(KIND_FIRED, i, 1'b1));
                        end
                        else
                        begin
                            if (repeats_tab[i] != 0)
                                repeats_tab[i] = repeats_tab[i] - 1'b1;
                            remaining_tab[i] = period_tab[i];
                            batch.push_back(make_result(KIND_FIRED, i, 1'b0));
                        end
                    end
                    fire_count += batch.size();
                    if (batch.size() == 0)
                    begin
                        idle_ticks++;
                        batch.push_back(make_result(KIND_IDLE_TICK, 0, 1'b0));
                    end
                end
                ACT_START:
                begin
                    if (per == 0)
                        batch.push_back(make_result(KIND_REJECTED, 0, 1'b0));
                    else
                    begin
                        for (int i = SLOTS_DEF - 1; i >= 0; i--)
                            if (period_tab[i] == 0)
                                free_slot = i;
                        if (free_slot >= 0)
                        begin
                            period_tab[free_slot]    = per;
                            remaining_tab[free_slot] = per;
                            repeats_tab[free_slot]   = rep;
                            live_count++;
                            batch.push_back(make_result(KIND_STARTED, free_slot, 1'b0));
                        end
                        else
                        begin
                            full_count++;
                            batch.push_back(make_result(KIND_FULL, 0, 1'b0));
                        end
                    end
                end
                ACT_CANCEL:
                begin
                    if (idx < SLOTS_DEF && period_tab[idx] != 0)
                    begin
                        period_tab[idx] = '0;
                        live_count--;
                        batch.push_back(make_result(KIND_CANCELLED, idx, 1'b0));
                    end
                    else
                        batch.push_back(make_result(KIND_REJECTED, 0, 1'b0));
                end
                default:
                begin
                    foreach (period_tab[i])
                        period_tab[i] = '0;
                    live_count = 0;
                    batch.push_back(make_result(KIND_ALL_CANCELLED, 0, 1'b0));
                end
            endcase
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                awaited.push_back(batch[i]);
        endfunction

        // Return a random active slot, or -1 when the table is empty
        function int pick_live_slot();
            int live [$];
            foreach (period_tab[i])
                if (period_tab[i] != 0)
                    live.push_back(i);
            if (live.size() == 0)
                return -1;
            return live[$urandom_range(0, live.size() - 1)];
        endfunction

        task report_mismatch(string msg);
            if (errors < 40)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want, int seq);
            if (got != want)
                report_mismatch($sformatf("response %0d field %s: got %0d, want %0d",
                                          seq, name, got, want));
        endtask

        // Compare one accepted response with the oldest awaited one
        task check_result(timer_result_t got);
            timer_result_t want;
            if ($isunknown(got))
            begin
                report_mismatch($sformatf("response %0d carries unknown bits", checked));
                void'(awaited.pop_front());
                checked++;
                return;
            end
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response kind %0d slot %0d",
                                          got.kind, got.slot));
                return;
            end
            want = awaited.pop_front();
            compare_field("result_kind", got.kind, want.kind, checked);
            compare_field("slot", got.slot, want.slot, checked);
            compare_field("final_fire", got.final_fire, want.final_fire, checked);
            compare_field("slots_in_use", got.in_use, want.in_use, checked);
            compare_field("last_of_run", got.last, want.last, checked);
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    stt_cmd_if cmd_bus ();
    stt_rsp_if rsp_bus ();

    software_timer_slot_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    timer_scoreboard sb = new();

    int unsigned cycle_count;
    int unsigned requests_sent;
    int          burst_left;
    bit          send_calm;
    bit          rsp_calm;
    bit          hold_wanted;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_request(logic [ACTION_W-1:0] act, logic [TICKS_W-1:0] per,
                                logic [TICKS_W-1:0] rep, logic [SLOT_FIELD_W-1:0] idx);
        int gap;
        cmd_bus.valid        <= 1'b1;
        cmd_bus.action       <= act;
        cmd_bus.period_ticks <= per;
        cmd_bus.repeat_count <= rep;
        cmd_bus.slot_index   <= idx;
        do
            @(negedge clk);
        while (cmd_bus.ready !== 1'b1);
        @(posedge clk);
        sb.note_request(act, per, rep, idx);
        requests_sent++;
        if ($urandom_range(0, 24) == 0)
            send_calm = ~send_calm;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Walk the extremes and several special cases
    task automatic run_directed();
        send_request(ACT_TICK,       8'd0,   8'd0,   5'd0);
        send_request(ACT_START,      8'd0,   8'd7,   5'd0);
        send_request(ACT_CANCEL,     8'd0,   8'd0,   5'd4);
        send_request(ACT_CANCEL,     8'd0,   8'd0,   5'd31);
        send_request(ACT_CANCEL_ALL, 8'd0,   8'd0,   5'd0);
        send_request(ACT_START,      8'd1,   8'd1,   5'd0);
        send_request(ACT_START,      8'd2,   8'd2,   5'd0);
        send_request(ACT_START,      8'd255, 8'd255, 5'd0);
        send_request(ACT_START,      8'd1,   8'd0,   5'd0);
        send_request(ACT_START,      8'd3,   8'd0,   5'd0);
        send_request(ACT_TICK,       8'd0,   8'd0,   5'd0);
        send_request(ACT_TICK,       8'd0,   8'd0,   5'd0);
        send_request(ACT_CANCEL,     8'd0,   8'd0,   5'd3);
        send_request(ACT_START,      8'd1,   8'd0,   5'd0);
        send_request(ACT_TICK,       8'd0,   8'd0,   5'd0);
        send_request(ACT_TICK,       8'd0,   8'd0,   5'd0);
        send_request(ACT_CANCEL,     8'd0,   8'd0,   5'd2);
        send_request(ACT_CANCEL,     8'd0,   8'd0,   5'd19);
        send_request(ACT_CANCEL_ALL, 8'd0,   8'd0,   5'd0);
        send_request(ACT_TICK,       8'd0,   8'd0,   5'd0);
    endtask

    // Draw one request: mostly live traffic, some fill bursts and noise
    task automatic send_random_request();
        logic [ACTION_W-1:0]     act;
        logic [TICKS_W-1:0]      per;
        logic [TICKS_W-1:0]      rep;
        logic [SLOT_FIELD_W-1:0] idx;
        int                      r;
        int                      live;
        per = TICKS_W'($urandom);
        rep = TICKS_W'($urandom);
        idx = SLOT_FIELD_W'($urandom);
        r   = $urandom_range(0, 99);
        if (burst_left == 0 && r >= 94)
            burst_left = $urandom_range(18, 24);
        if (burst_left > 0)
        begin
            burst_left--;
            act = ACT_START;
            per = TICKS_W'($urandom_range(1, 6));
            rep = TICKS_W'($urandom_range(0, 3));
        end
        else if (r < 38)
            act = ACT_TICK;
        else if (r < 72)
        begin
            act = ACT_START;
            r = $urandom_range(0, 99);
            if (r < 8)
                per = '0;
            else if (r < 80)
                per = TICKS_W'($urandom_range(1, 6));
            else
                per = TICKS_W'($urandom_range(1, 255));
            r = $urandom_range(0, 99);
            if (r < 40)
                rep = 8'd1;
            else if (r < 70)
                rep = 8'd0;
            else if (r < 90)
                rep = TICKS_W'($urandom_range(2, 5));
        end
        else if (r < 90)
        begin
            act  = ACT_CANCEL;
            live = sb.pick_live_slot();
            if (live >= 0 && $urandom_range(0, 9) < 7)
                idx = SLOT_FIELD_W'(live);
        end
        else
            act = ACT_CANCEL_ALL;
        send_request(act, per, rep, idx);
    endtask

    // Response ready: random stalls, calm stretches, one long hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        rsp_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if ($urandom_range(0, 299) == 0)
                rsp_calm = ~rsp_calm;
            if (hold_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                stall_left = pick_gap(rsp_calm);
            end
        end
    end

    // Check every response transaction
    always @(posedge clk)
    begin
        timer_result_t got;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.kind       = rsp_bus.result_kind;
            got.slot       = rsp_bus.slot;
            got.final_fire = rsp_bus.final_fire;
            got.in_use     = rsp_bus.slots_in_use;
            got.last       = rsp_bus.last_of_run;
            sb.check_result(got);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, sb.awaited.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Reset, stimulus, drain and verdict
    initial
    begin
        cycle_count   = 0;
        requests_sent = 0;
        burst_left    = 0;
        send_calm     = 1'b0;
        rsp_calm      = 1'b0;
        hold_wanted   = 1'b0;
        rst_n                <= 1'b0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.action       <= ACT_TICK;
        cmd_bus.period_ticks <= '0;
        cmd_bus.repeat_count <= '0;
        cmd_bus.slot_index   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 40)
                hold_wanted = 1'b1;
            send_random_request();
        end
        cmd_bus.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d requests and checked %0d responses in %0d cycles.",
                 requests_sent, sb.checked, cycle_count);
        $display("Saw %0d firings, %0d table-full answers and %0d idle ticks.",
                 sb.fire_count, sb.full_count, sb.idle_ticks);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
